>>> hdl/printable_run_scanner_top_macros.svh
// ---------------------------------------------------------------------------
// Printable run scanner assertion macros
// Shared assertion forms for the scanner modules.
// ---------------------------------------------------------------------------
`ifndef PRINTABLE_RUN_SCANNER_TOP_MACROS_SVH
`define PRINTABLE_RUN_SCANNER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/prs_pkg.sv
// ---------------------------------------------------------------------------
// Printable run scanner package
// Register indexes, reset values, configuration type and byte class helper.
// ---------------------------------------------------------------------------
package prs_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 48;
    localparam int MIN_LEN_W   = 16;
    localparam int LIMIT_W     = 48;

    localparam logic [CFG_INDEX_W-1:0] REG_MIN_LENGTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_ASCII = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_WIDE  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SCAN_LIMIT   = 2'd3;

    localparam logic [MIN_LEN_W-1:0] MIN_LENGTH_RESET = 16'd5;

    localparam logic [7:0] PRINT_LOW  = 8'h20;
    localparam logic [7:0] PRINT_HIGH = 8'h7E;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;

    // Result queue: one transfer may produce up to two results.
    localparam int RES_DEPTH = 4;
    localparam int PTR_W     = 2;
    localparam int COUNT_W   = 3;
    localparam int PUSH_W    = 2;

    typedef struct packed {
        logic [MIN_LEN_W-1:0] min_length;
        logic                 search_ascii;
        logic                 search_wide;
        logic [LIMIT_W-1:0]   scan_limit;
    } t_cfg;

    function automatic logic f_printable(input logic [7:0] b);
        return (b >= PRINT_LOW) && (b <= PRINT_HIGH);
    endfunction

endpackage

>>> hdl/prs_cfg.sv
// ---------------------------------------------------------------------------
// Printable run scanner configuration registers
// Holds the four run-time settings written through the plain write port.
// ---------------------------------------------------------------------------
module prs_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [prs_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [prs_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output prs_pkg::t_cfg                        o_cfg
);

    prs_pkg::t_cfg r_cfg;
    prs_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                prs_pkg::REG_MIN_LENGTH: begin
                    n_cfg.min_length = i_cfg_data[prs_pkg::MIN_LEN_W-1:0];
                end
                prs_pkg::REG_SEARCH_ASCII: begin
                    n_cfg.search_ascii = i_cfg_data[0];
                end
                prs_pkg::REG_SEARCH_WIDE: begin
                    n_cfg.search_wide = i_cfg_data[0];
                end
                prs_pkg::REG_SCAN_LIMIT: begin
                    n_cfg.scan_limit = i_cfg_data[prs_pkg::LIMIT_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_length   <= prs_pkg::MIN_LENGTH_RESET;
            r_cfg.search_ascii <= 1'b1;
            r_cfg.search_wide  <= 1'b1;
            r_cfg.scan_limit   <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hdl/prs_core.sv
// ---------------------------------------------------------------------------
// Printable run scanner core
// Input register, run state and the combinational judging of one byte.
// ---------------------------------------------------------------------------
`include "printable_run_scanner_top_macros.svh"

module prs_core #(
    parameter int OFFSET_WIDTH = 48,
    parameter int LENGTH_WIDTH = 16,
    parameter int RES_W        = OFFSET_WIDTH + LENGTH_WIDTH + 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_end_of_stream,
    input  prs_pkg::t_cfg                 i_cfg,
    output logic                          o_stage_valid,
    output logic [prs_pkg::PUSH_W-1:0]    o_push_count,
    output logic [RES_W-1:0]              o_result0,
    output logic [RES_W-1:0]              o_result1
);

    typedef struct packed {
        logic                    wide_open;
        logic                    ascii_open;
        logic [OFFSET_WIDTH-1:0] run_start;
        logic [LENGTH_WIDTH-1:0] run_count;
    } t_run;

    typedef struct packed {
        t_run                    run;
        logic                    consumed;
        logic                    rep;
        logic                    rep_wide;
        logic [OFFSET_WIDTH-1:0] rep_start;
        logic [LENGTH_WIDTH-1:0] rep_count;
    } t_judge;

    function automatic logic f_meets(input logic [LENGTH_WIDTH-1:0] cnt,
                                     input logic [prs_pkg::MIN_LEN_W-1:0] min_len);
        return 32'(cnt) >= 32'(min_len);
    endfunction

    function automatic logic [LENGTH_WIDTH-1:0] f_bump(input logic [LENGTH_WIDTH-1:0] cnt);
        return (cnt == {LENGTH_WIDTH{1'b1}}) ? cnt : cnt + LENGTH_WIDTH'(1);
    endfunction

    function automatic t_judge f_judge(input t_run s, input logic [7:0] cur,
                                       input logic has_next, input logic [7:0] nxt,
                                       input logic [OFFSET_WIDTH-1:0] pos,
                                       input prs_pkg::t_cfg cfg);
        t_judge j;
        j           = '0;
        j.run       = s;
        j.rep_start = s.run_start;
        j.rep_count = s.run_count;
        if (cfg.search_wide && !j.run.ascii_open) begin
            if (cur == prs_pkg::ZERO_BYTE && has_next && prs_pkg::f_printable(nxt)) begin
                if (!j.run.wide_open) begin
                    j.run.wide_open = 1'b1;
                    j.run.run_start = pos;
                    j.run.run_count = '0;
                end
                j.run.run_count = f_bump(j.run.run_count);
                j.consumed      = 1'b1;
            end else if (j.run.wide_open) begin
                j.rep           = f_meets(s.run_count, cfg.min_length);
                j.rep_wide      = 1'b1;
                j.run.wide_open = 1'b0;
            end
        end
        if (!j.consumed && cfg.search_ascii && !j.run.wide_open) begin
            if (prs_pkg::f_printable(cur)) begin
                if (!j.run.ascii_open) begin
                    j.run.ascii_open = 1'b1;
                    j.run.run_start  = pos;
                    j.run.run_count  = '0;
                end
                j.run.run_count = f_bump(j.run.run_count);
            end else if (j.run.ascii_open) begin
                j.rep            = f_meets(s.run_count, cfg.min_length);
                j.rep_wide       = 1'b0;
                j.run.ascii_open = 1'b0;
            end
        end
        return j;
    endfunction

    function automatic logic [RES_W-1:0] f_pack(input logic [OFFSET_WIDTH-1:0] start,
                                                input logic [LENGTH_WIDTH-1:0] cnt,
                                                input logic wide, input logic last);
        return {start, cnt, wide, last};
    endfunction

    logic                    r_stg_valid;
    logic [7:0]              r_stg_byte;
    logic                    r_stg_eos;
    t_run                    r_run;
    t_run                    n_run;
    logic [7:0]              r_held_byte;
    logic [7:0]              n_held_byte;
    logic                    r_held_valid;
    logic                    n_held_valid;
    logic [OFFSET_WIDTH-1:0] r_pos;
    logic [OFFSET_WIDTH-1:0] n_pos;
    logic                    r_limit_reached;
    logic                    n_limit_reached;

    always_comb begin : p_step
        t_run                    v_run;
        t_judge                  v_j1;
        t_judge                  v_j2;
        logic                    v_held_valid;
        logic [7:0]              v_held_byte;
        logic [OFFSET_WIDTH-1:0] v_pos_next;
        logic [OFFSET_WIDTH-1:0] v_limit;
        logic                    v_hit;
        logic                    v_fl;
        logic                    v_fl_wide;
        logic [OFFSET_WIDTH-1:0] v_fl_start;
        logic [LENGTH_WIDTH-1:0] v_fl_count;

        v_run           = r_run;
        v_j1            = '0;
        v_j2            = '0;
        v_held_valid    = r_held_valid;
        v_held_byte     = r_held_byte;
        v_pos_next      = r_pos + OFFSET_WIDTH'(1);
        v_limit         = OFFSET_WIDTH'(i_cfg.scan_limit);
        v_hit           = 1'b0;
        v_fl            = 1'b0;
        v_fl_wide       = 1'b0;
        v_fl_start      = r_run.run_start;
        v_fl_count      = r_run.run_count;
        n_run           = r_run;
        n_held_byte     = r_held_byte;
        n_held_valid    = r_held_valid;
        n_pos           = r_pos;
        n_limit_reached = r_limit_reached;
        o_push_count    = '0;
        o_result0       = '0;
        o_result1       = '0;

        if (r_stg_valid) begin
            if (r_limit_reached) begin
                if (r_stg_eos) begin
                    n_limit_reached = 1'b0;
                end
            end else begin
                if (r_held_valid) begin
                    v_j1  = f_judge(v_run, r_held_byte, 1'b1, r_stg_byte,
                                    r_pos - OFFSET_WIDTH'(1), i_cfg);
                    v_run = v_j1.run;
                end
                if (v_j1.consumed) begin
                    v_held_valid = 1'b0;
                end else begin
                    v_held_byte  = r_stg_byte;
                    v_held_valid = 1'b1;
                end
                v_hit        = (v_limit != '0) && (v_pos_next == v_limit);
                n_run        = v_run;
                n_held_byte  = v_held_byte;
                n_held_valid = v_held_valid;
                n_pos        = v_pos_next;
                if (r_stg_eos || v_hit) begin
                    if (v_held_valid) begin
                        v_j2  = f_judge(v_run, v_held_byte, 1'b0, prs_pkg::ZERO_BYTE,
                                        r_pos, i_cfg);
                        v_run = v_j2.run;
                    end
                    v_fl = (v_run.wide_open || v_run.ascii_open)
                           && f_meets(v_run.run_count, i_cfg.min_length);
                    v_fl_wide    = v_run.wide_open;
                    v_fl_start   = v_run.run_start;
                    v_fl_count   = v_run.run_count;
                    n_run        = '0;
                    n_held_byte  = '0;
                    n_held_valid = 1'b0;
                    n_pos        = '0;
                    if (v_hit && !r_stg_eos) begin
                        n_limit_reached = 1'b1;
                    end
                end
            end
        end

        // At most two results leave per byte; a third candidate is dropped.
        if (v_j1.rep) begin
            if (v_j2.rep) begin
                o_result0    = f_pack(v_j1.rep_start, v_j1.rep_count, v_j1.rep_wide, 1'b0);
                o_result1    = f_pack(v_j2.rep_start, v_j2.rep_count, v_j2.rep_wide, 1'b1);
                o_push_count = 2'd2;
            end else if (v_fl) begin
                o_result0    = f_pack(v_j1.rep_start, v_j1.rep_count, v_j1.rep_wide, 1'b0);
                o_result1    = f_pack(v_fl_start, v_fl_count, v_fl_wide, 1'b1);
                o_push_count = 2'd2;
            end else begin
                o_result0    = f_pack(v_j1.rep_start, v_j1.rep_count, v_j1.rep_wide, 1'b1);
                o_push_count = 2'd1;
            end
        end else if (v_j2.rep) begin
            if (v_fl) begin
                o_result0    = f_pack(v_j2.rep_start, v_j2.rep_count, v_j2.rep_wide, 1'b0);
                o_result1    = f_pack(v_fl_start, v_fl_count, v_fl_wide, 1'b1);
                o_push_count = 2'd2;
            end else begin
                o_result0    = f_pack(v_j2.rep_start, v_j2.rep_count, v_j2.rep_wide, 1'b1);
                o_push_count = 2'd1;
            end
        end else if (v_fl) begin
            o_result0    = f_pack(v_fl_start, v_fl_count, v_fl_wide, 1'b1);
            o_push_count = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid     <= 1'b0;
            r_run           <= '0;
            r_held_byte     <= '0;
            r_held_valid    <= 1'b0;
            r_pos           <= '0;
            r_limit_reached <= 1'b0;
        end else begin
            r_stg_valid     <= i_take;
            r_run           <= n_run;
            r_held_byte     <= n_held_byte;
            r_held_valid    <= n_held_valid;
            r_pos           <= n_pos;
            r_limit_reached <= n_limit_reached;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_stg_byte <= i_data_byte;
            r_stg_eos  <= i_end_of_stream;
        end
    end

    assign o_stage_valid = r_stg_valid;

    `PRS_ASSERT_NOW(a_single_run_kind, i_clk, i_rst_n, 1'b1,
                    !(r_run.wide_open && r_run.ascii_open),
                    "Wide and ASCII runs are open at the same time.")
    `PRS_ASSERT_NOW(a_limit_idle_stream, i_clk, i_rst_n, r_limit_reached,
                    !r_held_valid && !r_run.wide_open && !r_run.ascii_open && r_pos == '0,
                    "Stream state is not cleared while the scan limit holds.")
    `PRS_ASSERT_NEXT(a_eos_clears, i_clk, i_rst_n, r_stg_valid && r_stg_eos,
                     r_pos == '0 && !r_held_valid && !r_limit_reached,
                     "End of stream did not return the stream state to reset.")

endmodule

>>> hdl/prs_fifo.sv
// ---------------------------------------------------------------------------
// Printable run scanner result queue
// Four-entry queue that takes up to two results per cycle and gives one while the reader is ready.
// ---------------------------------------------------------------------------
`include "printable_run_scanner_top_macros.svh"

module prs_fifo #(
    parameter int WIDTH = 66
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [prs_pkg::PUSH_W-1:0]      i_push_count,
    input  logic [WIDTH-1:0]                i_data0,
    input  logic [WIDTH-1:0]                i_data1,
    input  logic                            i_ready,
    output logic                            o_valid,
    output logic [WIDTH-1:0]                o_data,
    output logic [prs_pkg::COUNT_W-1:0]     o_count
);

    logic [WIDTH-1:0]                r_mem [prs_pkg::RES_DEPTH];
    logic [prs_pkg::PTR_W-1:0]       r_wptr;
    logic [prs_pkg::PTR_W-1:0]       n_wptr;
    logic [prs_pkg::PTR_W-1:0]       r_rptr;
    logic [prs_pkg::PTR_W-1:0]       n_rptr;
    logic [prs_pkg::COUNT_W-1:0]     r_count;
    logic [prs_pkg::COUNT_W-1:0]     n_count;
    logic                            w_pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign o_count = r_count;
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_wptr  = r_wptr + prs_pkg::PTR_W'(i_push_count);
        n_rptr  = r_rptr + prs_pkg::PTR_W'(w_pop);
        n_count = r_count + prs_pkg::COUNT_W'(i_push_count) - prs_pkg::COUNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_count != '0) begin
            r_mem[r_wptr] <= i_data0;
        end
        if (i_push_count == prs_pkg::PUSH_W'(2)) begin
            r_mem[r_wptr + prs_pkg::PTR_W'(1)] <= i_data1;
        end
    end

    `PRS_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, 1'b1,
                    32'(r_count) + 32'(i_push_count) - 32'(w_pop) <= prs_pkg::RES_DEPTH,
                    "Result queue overflow.")

endmodule

>>> hdl/printable_run_scanner_top.sv
// ---------------------------------------------------------------------------
// Printable run scanner
// Finds ASCII and wide printable runs in a byte stream and reports each run
// that ends and meets the minimum length with its start offset, length and kind.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  input     in         i_valid / o_ready      i_data_byte, i_end_of_stream
//  result    out        o_valid / i_ready      o_run_offset, o_run_length,
//                                              o_run_is_wide, o_last_result
//  config    in         i_cfg_we               i_cfg_index, i_cfg_data
//
// One byte can be taken in every cycle while o_ready is high; a taken byte is
// registered and judged from the stage or held byte register, and its results are registered in the queue.
// Intake pauses while the queued results, two for the byte being judged and two
// for the next byte would overfill the four-entry queue, counting a result that
// leaves in the same cycle; a byte with two results can pause intake even while
// the consumer takes a result in every cycle.
// Reset is synchronous and active low.
// ---------------------------------------------------------------------------
module printable_run_scanner_top #(
    parameter int OFFSET_WIDTH = 48,
    parameter int LENGTH_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_end_of_stream,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [OFFSET_WIDTH-1:0]           o_run_offset,
    output logic [LENGTH_WIDTH-1:0]           o_run_length,
    output logic                              o_run_is_wide,
    output logic                              o_last_result,
    input  logic                              i_cfg_we,
    input  logic [prs_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [prs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int RES_W = OFFSET_WIDTH + LENGTH_WIDTH + 2;

    prs_pkg::t_cfg                  w_cfg;
    logic                           w_take;
    logic                           w_stage_valid;
    logic [prs_pkg::PUSH_W-1:0]     w_push_count;
    logic [RES_W-1:0]               w_result0;
    logic [RES_W-1:0]               w_result1;
    logic [RES_W-1:0]               w_head;
    logic [prs_pkg::COUNT_W-1:0]    w_count;
    logic [3:0]                     w_need;
    logic [3:0]                     w_room;

    // Room is kept for two results of the byte in flight and two of the new one.
    assign w_need  = 4'(w_count) + (w_stage_valid ? 4'd2 : 4'd0) + 4'd2;
    assign w_room  = 4'(prs_pkg::RES_DEPTH) + 4'(o_valid && i_ready);
    assign o_ready = (w_need <= w_room);
    assign w_take  = i_valid && o_ready;

    prs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    prs_core #(
        .OFFSET_WIDTH (OFFSET_WIDTH),
        .LENGTH_WIDTH (LENGTH_WIDTH),
        .RES_W        (RES_W)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (w_take),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .i_cfg           (w_cfg),
        .o_stage_valid   (w_stage_valid),
        .o_push_count    (w_push_count),
        .o_result0       (w_result0),
        .o_result1       (w_result1)
    );

    prs_fifo #(
        .WIDTH (RES_W)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (w_push_count),
        .i_data0      (w_result0),
        .i_data1      (w_result1),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_data       (w_head),
        .o_count      (w_count)
    );

    assign o_run_offset  = w_head[RES_W-1 -: OFFSET_WIDTH];
    assign o_run_length  = w_head[LENGTH_WIDTH+1 -: LENGTH_WIDTH];
    assign o_run_is_wide = w_head[1];
    assign o_last_result = w_head[0];

endmodule
